// ===== hw/rtl/calendar_datetime_to_epoch_assert.svh =====
// Assertion macros for the calendar-to-epoch converter.
// Depends on nothing; included by the top level just before its checks.
`ifndef CALENDAR_DATETIME_TO_EPOCH_ASSERT_SVH
`define CALENDAR_DATETIME_TO_EPOCH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CDTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CDTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cdte_pkg.sv =====
// Shared types, constants and calendar helper functions for the
// calendar-to-epoch converter. No dependencies.
package cdte_pkg;

  localparam logic [11:0] YEAR_FIRST    = 12'd2000;
  localparam logic [11:0] YEAR_LAST     = 12'd2099;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [4:0]  HOUR_MAX      = 5'd23;
  localparam logic [5:0]  MINSEC_MAX    = 6'd59;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;
  // 2000-01-01 was a Saturday (6 with Monday as 1).
  localparam logic [15:0] WDAY_OFFSET   = 16'd5;

  typedef struct packed {
    logic [11:0] calendar_year;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
  } in_t;

  typedef struct packed {
    logic        datetime_valid;
    logic [31:0] seconds_since_2000;
    logic [2:0]  weekday;
    logic [7:0]  bcd_year;
    logic [4:0]  bcd_month;
    logic [5:0]  bcd_day;
    logic [5:0]  bcd_hour;
    logic [6:0]  bcd_minute;
    logic [6:0]  bcd_second;
  } out_t;

  // After range checks.
  typedef struct packed {
    logic       ok;
    logic [6:0] year_ofs;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [8:0] days_before_month;
  } s1_t;

  // After day and time-of-day counts.
  typedef struct packed {
    logic        ok;
    logic [15:0] day_count;
    logic [16:0] tod_secs;
    logic [7:0]  bcd_year;
    logic [4:0]  bcd_month;
    logic [5:0]  bcd_day;
    logic [5:0]  bcd_hour;
    logic [6:0]  bcd_minute;
    logic [6:0]  bcd_second;
  } s2_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
        4'd2:                                       len = leap ? 5'd29 : 5'd28;
        default:                                    len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // Days in the year before the first of month m, no leap day.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    begin
      case (m)
        4'd1:    d = 9'd0;
        4'd2:    d = 9'd31;
        4'd3:    d = 9'd59;
        4'd4:    d = 9'd90;
        4'd5:    d = 9'd120;
        4'd6:    d = 9'd151;
        4'd7:    d = 9'd181;
        4'd8:    d = 9'd212;
        4'd9:    d = 9'd243;
        4'd10:   d = 9'd273;
        4'd11:   d = 9'd304;
        4'd12:   d = 9'd334;
        default: d = 9'd0;
      endcase
      return d;
    end
  endfunction

  // Two BCD digits of v (v below 100); tens by multiply with 205 / 2048.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    begin
      prod  = 15'(v) * 15'd205;
      tens  = prod[14:11];
      units = v - 7'(tens) * 7'd10;
      return {tens, units[3:0]};
    end
  endfunction

  // v mod 7 by folding octal digits (8 is 1 mod 7).
  function automatic logic [2:0] mod7(input logic [15:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    begin
      s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
         + 6'(v[15]);
      s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
      s3 = 4'(s2[3]) + 4'(s2[2:0]);
      return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    end
  endfunction

endpackage

// ===== hw/rtl/cdte_check.sv =====
// First stage: range checks and month lookup.
// Depends on cdte_pkg.
module cdte_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  cdte_pkg::in_t in_word,
  output logic          s1_vld_r,
  output cdte_pkg::s1_t s1_r
);
  import cdte_pkg::*;

  s1_t        s1_nxt;
  logic [6:0] year_ofs;
  logic       year_ok;
  logic       leap;
  logic [4:0] mlen;

  always_comb begin
    year_ok  = (in_word.calendar_year >= YEAR_FIRST) && (in_word.calendar_year <= YEAR_LAST);
    year_ofs = 7'(in_word.calendar_year - YEAR_FIRST);
    // 2000 is a leap year by the 400 rule, so in range it is just year mod 4.
    leap     = (year_ofs[1:0] == 2'd0);
    mlen     = month_len(in_word.month_number, leap);

    s1_nxt.ok = year_ok
             && (in_word.month_number >= 4'd1) && (in_word.month_number <= MONTH_DEC)
             && (in_word.day_of_month >= 5'd1) && (in_word.day_of_month <= mlen)
             && (in_word.hour_of_day <= HOUR_MAX)
             && (in_word.minute_of_hour <= MINSEC_MAX)
             && (in_word.second_of_minute <= MINSEC_MAX);
    s1_nxt.year_ofs          = year_ofs;
    s1_nxt.month             = in_word.month_number;
    s1_nxt.day               = in_word.day_of_month;
    s1_nxt.hour              = in_word.hour_of_day;
    s1_nxt.minute            = in_word.minute_of_hour;
    s1_nxt.second            = in_word.second_of_minute;
    s1_nxt.days_before_month = days_before(in_word.month_number)
                             + 9'((leap && (in_word.month_number > MONTH_FEB)) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

// ===== hw/rtl/cdte_count.sv =====
// Second stage: day count since 2000-01-01, seconds into the day, BCD digits.
// Depends on cdte_pkg.
module cdte_count (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_vld,
  input  cdte_pkg::s1_t s1,
  output logic          s2_vld_r,
  output cdte_pkg::s2_t s2_r
);
  import cdte_pkg::*;

  s2_t        s2_nxt;
  logic [7:0] yr_plus3;

  always_comb begin
    yr_plus3 = 8'(s1.year_ofs) + 8'd3;
    s2_nxt.ok = s1.ok;
    // Whole years: 365 per year plus one leap day per started group of four.
    s2_nxt.day_count = 16'(s1.year_ofs) * 16'd365 + 16'(yr_plus3[7:2])
                     + 16'(s1.days_before_month) + 16'(s1.day) - 16'd1;
    s2_nxt.tod_secs  = 17'(s1.hour) * 17'(SECS_PER_HOUR) + 17'(s1.minute) * 17'd60
                     + 17'(s1.second);
    s2_nxt.bcd_year   = to_bcd(s1.year_ofs);
    s2_nxt.bcd_month  = 5'(to_bcd(7'(s1.month)));
    s2_nxt.bcd_day    = 6'(to_bcd(7'(s1.day)));
    s2_nxt.bcd_hour   = 6'(to_bcd(7'(s1.hour)));
    s2_nxt.bcd_minute = 7'(to_bcd(7'(s1.minute)));
    s2_nxt.bcd_second = 7'(to_bcd(7'(s1.second)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

endmodule

// ===== hw/rtl/cdte_merge.sv =====
// Third stage: seconds total, weekday, zeroing of invalid words; output register.
// Depends on cdte_pkg.
module cdte_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s2_vld,
  input  cdte_pkg::s2_t  s2,
  output logic           out_vld_r,
  output cdte_pkg::out_t out_r
);
  import cdte_pkg::*;

  out_t        out_nxt;
  logic [31:0] secs;
  logic [2:0]  wday;

  always_comb begin
    secs = 32'(s2.day_count) * 32'(SECS_PER_DAY) + 32'(s2.tod_secs);
    wday = mod7(s2.day_count + WDAY_OFFSET) + 3'd1;
    out_nxt = '0;
    if (s2.ok) begin
      out_nxt.datetime_valid     = 1'b1;
      out_nxt.seconds_since_2000 = secs;
      out_nxt.weekday            = wday;
      out_nxt.bcd_year           = s2.bcd_year;
      out_nxt.bcd_month          = s2.bcd_month;
      out_nxt.bcd_day            = s2.bcd_day;
      out_nxt.bcd_hour           = s2.bcd_hour;
      out_nxt.bcd_minute         = s2.bcd_minute;
      out_nxt.bcd_second         = s2.bcd_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// ===== hw/rtl/calendar_datetime_to_epoch.sv =====
// Calendar date/time to seconds since 2000-01-01 00:00:00, with weekday and
// BCD fields. Three-stage pipeline: take one word per clock on start, and
// expect its result on out_strobe from the stage-three register, in order.
// busy is held low: every stage advances every cycle, so the block never
// refuses a word, and the receiver must take each result in the cycle it
// shows. Stage one checks ranges and looks up the month; stage two forms the
// day count and seconds into the day; stage three multiplies by 86400, folds
// the weekday mod 7 and zeroes every field of an out-of-range word
// (datetime_valid low). Reset clears the valid bits only.
// Depends on cdte_pkg, cdte_check, cdte_count, cdte_merge and the assert header.
module calendar_datetime_to_epoch (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cdte_pkg::in_t  in_word,
  output logic           out_strobe,
  output cdte_pkg::out_t out_word
);
  import cdte_pkg::*;

  logic in_vld;
  logic s1_vld;
  s1_t  s1;
  logic s2_vld;
  s2_t  s2;

  // Never stall: the pipe has no hold path.
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  cdte_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_word  (in_word),
    .s1_vld_r (s1_vld),
    .s1_r     (s1)
  );

  cdte_count u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_vld   (s1_vld),
    .s1       (s1),
    .s2_vld_r (s2_vld),
    .s2_r     (s2)
  );

  cdte_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_vld    (s2_vld),
    .s2        (s2),
    .out_vld_r (out_strobe),
    .out_r     (out_word)
  );

`include "calendar_datetime_to_epoch_assert.svh"

  // A strobe only for an accepted word that has passed every stage register.
  `CDTE_ASSERT_NOW(a_strobe_origin, clk, rst_n, out_strobe, $past(in_vld, 3), "cdte: strobe without word")
  // Valid bits move one stage per cycle.
  `CDTE_ASSERT_NEXT(a_stage_advance, clk, rst_n, s2_vld, out_strobe, "cdte: stage two word lost")
  // Rejected words carry all-zero results.
  `CDTE_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_strobe && !out_word.datetime_valid, (out_word.seconds_since_2000 == 32'd0) && (out_word.weekday == 3'd0) && (out_word.bcd_year == 8'd0), "cdte: invalid word not zeroed")
  // Accepted words have a weekday and stay within the century.
  `CDTE_ASSERT_NOW(a_valid_range, clk, rst_n, out_strobe && out_word.datetime_valid, (out_word.weekday != 3'd0) && (out_word.seconds_since_2000 < 32'd3155760000), "cdte: result out of range")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for calendar_datetime_to_epoch: a queue-fed driver, an
// in-order result checker against a local calendar predictor, and a watchdog.
// Depends on cdte_pkg and the converter RTL only.
module tb;

  import cdte_pkg::*;

  localparam int unsigned FIRST_YEAR     = 2000;
  localparam int unsigned LAST_YEAR      = 2099;
  localparam int unsigned RANDOM_WORDS   = 1525;
  localparam int unsigned QUIET_TAIL     = 200;  // final words sent back to back
  localparam int unsigned PIPE_LATENCY   = 3;
  localparam int unsigned WATCHDOG_LIMIT = 200;

  // One pending date word plus how it is to be sent.
  typedef struct {
    in_t         word;
    int unsigned gap;    // idle cycles to insert before this word
    bit          drain;  // hold this word until every result is back
  } pending_date_t;

  logic clk;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  in_t  in_word = '0;
  logic out_strobe;
  out_t out_word;

  pending_date_t date_queue[$];
  out_t          expected_epochs[$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;

  calendar_datetime_to_epoch uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
  endfunction

  // Gregorian month length; zero for a month number out of range.
  function automatic int unsigned gregorian_month_days(input int unsigned y,
                                                       input int unsigned m);
    int unsigned len;
    begin
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        4, 6, 9, 11:           len = 30;
        2:                     len = is_leap_year(y) ? 29 : 28;
        default:               len = 0;
      endcase
      return len;
    end
  endfunction

  function automatic logic [7:0] to_packed_bcd(input int unsigned v);
    return {4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  function automatic in_t make_date(input int unsigned y, input int unsigned mo,
                                    input int unsigned d, input int unsigned hr,
                                    input int unsigned mi, input int unsigned se);
    in_t w;
    begin
      w.calendar_year    = 12'(y);
      w.month_number     = 4'(mo);
      w.day_of_month     = 5'(d);
      w.hour_of_day      = 5'(hr);
      w.minute_of_hour   = 6'(mi);
      w.second_of_minute = 6'(se);
      return w;
    end
  endfunction

  // Expected converter output for one date word.
  function automatic out_t predict_epoch(input in_t w);
    out_t        r;
    int unsigned y, mo, d, hr, mi, se, yo, days, ay, wd, shift, k;
    logic [63:0] secs;
    bit          ok;
    begin
      r  = '0;
      y  = 32'(w.calendar_year);
      mo = 32'(w.month_number);
      d  = 32'(w.day_of_month);
      hr = 32'(w.hour_of_day);
      mi = 32'(w.minute_of_hour);
      se = 32'(w.second_of_minute);
      ok = (y >= FIRST_YEAR) && (y <= LAST_YEAR) && (mo >= 1) && (mo <= 12) &&
           (d >= 1) && (d <= gregorian_month_days(y, mo)) && (hr <= 23) && (mi <= 59) &&
           (se <= 59);
      if (ok) begin
        // Whole years by closed form, exact over 2000..2099.
        yo   = y - FIRST_YEAR;
        days = 365 * yo + (yo + 3) / 4;
        for (k = 1; k < mo; k++) days += gregorian_month_days(y, k);
        days += d - 1;
        secs = 64'(days) * 64'd86400 + 64'(hr) * 64'd3600 + 64'(mi) * 64'd60 + 64'(se);
        // Sakamoto's weekday, shifted so Monday is 1 and Sunday is 7.
        case (mo)
          1, 5:   shift = 0;
          2, 6:   shift = 3;
          3, 11:  shift = 2;
          4:      shift = 5;
          7:      shift = 5;
          8:      shift = 1;
          9, 12:  shift = 4;
          default: shift = 6;
        endcase
        ay = (mo < 3) ? y - 1 : y;
        wd = (ay + ay / 4 - ay / 100 + ay / 400 + shift + d) % 7;
        if (wd == 0) wd = 7;
        r.datetime_valid     = 1'b1;
        r.seconds_since_2000 = secs[31:0];
        r.weekday            = 3'(wd);
        r.bcd_year           = to_packed_bcd(yo);
        r.bcd_month          = 5'(to_packed_bcd(mo));
        r.bcd_day            = 6'(to_packed_bcd(d));
        r.bcd_hour           = 6'(to_packed_bcd(hr));
        r.bcd_minute         = 7'(to_packed_bcd(mi));
        r.bcd_second         = 7'(to_packed_bcd(se));
      end
      return r;
    end
  endfunction

  task automatic queue_date(input in_t w, input int unsigned gap, input bit drain);
    pending_date_t p;
    begin
      p.word  = w;
      p.gap   = gap;
      p.drain = drain;
      date_queue.push_back(p);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: send the next word once the last is taken and its gap and drain allow.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Hold the word until the block takes it.
    end else begin
      if (start) expected_epochs.push_back(predict_epoch(in_word));
      if (date_queue.size() == 0) begin
        start <= 1'b0;
      end else if (date_queue[0].gap != 0) begin
        // Count down the gap ahead of this word while holding start low.
        date_queue[0].gap = date_queue[0].gap - 1;
        start <= 1'b0;
      end else if (date_queue[0].drain && expected_epochs.size() != 0) begin
        // Hold off until the pipeline has emptied.
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        in_word <= date_queue[0].word;
        date_queue.pop_front();
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation, and
  // count cycles in which nothing moves for the watchdog.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_epochs.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none actual 0x%0h",
                   $time, out_word);
          mismatch_count++;
        end else begin
          want = expected_epochs.pop_front();
          check_field("datetime_valid", 32'(want.datetime_valid), 32'(out_word.datetime_valid));
          check_field("seconds_since_2000", want.seconds_since_2000,
                      out_word.seconds_since_2000);
          check_field("weekday", 32'(want.weekday), 32'(out_word.weekday));
          check_field("bcd_year", 32'(want.bcd_year), 32'(out_word.bcd_year));
          check_field("bcd_month", 32'(want.bcd_month), 32'(out_word.bcd_month));
          check_field("bcd_day", 32'(want.bcd_day), 32'(out_word.bcd_day));
          check_field("bcd_hour", 32'(want.bcd_hour), 32'(out_word.bcd_hour));
          check_field("bcd_minute", 32'(want.bcd_minute), 32'(out_word.bcd_minute));
          check_field("bcd_second", 32'(want.bcd_second), 32'(out_word.bcd_second));
        end
      end
      if (out_strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: end the run when nothing has moved for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned idx, kind, y, mo, d, hr, mi, se, len, gap;
    bit          bursty;
    rst_n = 1'b0;

    // Directed words: range edges, leap rules, weekday branches.
    queue_date(make_date(2000, 1, 1, 0, 0, 0), 0, 0);        // epoch zero
    queue_date(make_date(2099, 12, 31, 23, 59, 59), 0, 0);   // last valid second
    queue_date(make_date(1999, 12, 31, 23, 59, 59), 0, 0);   // year below range
    queue_date(make_date(2100, 1, 1, 0, 0, 0), 0, 0);        // year above range
    queue_date(make_date(0, 1, 1, 0, 0, 0), 0, 0);
    queue_date(make_date(4095, 15, 31, 31, 63, 63), 0, 0);   // every bit set
    queue_date(make_date(2050, 0, 10, 12, 30, 30), 0, 0);    // month zero
    queue_date(make_date(2050, 13, 10, 12, 30, 30), 0, 0);   // month past December
    queue_date(make_date(2050, 6, 0, 12, 30, 30), 0, 0);     // day zero
    queue_date(make_date(2050, 4, 31, 12, 30, 30), 0, 0);    // past end of April
    queue_date(make_date(2050, 1, 31, 12, 30, 30), 0, 0);
    queue_date(make_date(2000, 2, 29, 6, 0, 0), 2, 0);       // leap by the 400 rule
    queue_date(make_date(2004, 2, 29, 6, 0, 0), 0, 0);       // ordinary leap year
    queue_date(make_date(2001, 2, 29, 6, 0, 0), 0, 0);       // no leap day
    queue_date(make_date(2001, 2, 28, 6, 0, 0), 0, 0);
    queue_date(make_date(2000, 3, 1, 0, 0, 0), 0, 0);        // first March weekday
    queue_date(make_date(2024, 2, 30, 0, 0, 0), 0, 0);
    queue_date(make_date(2030, 7, 15, 23, 0, 0), 1, 0);
    queue_date(make_date(2030, 7, 15, 24, 0, 0), 0, 0);      // hour out of range
    queue_date(make_date(2030, 7, 15, 31, 0, 0), 0, 0);
    queue_date(make_date(2030, 7, 15, 0, 60, 0), 0, 0);      // minute out of range
    queue_date(make_date(2030, 7, 15, 0, 63, 0), 0, 0);
    queue_date(make_date(2030, 7, 15, 0, 0, 60), 0, 0);      // second out of range
    queue_date(make_date(2030, 7, 15, 0, 0, 63), 0, 0);
    queue_date(make_date(2087, 12, 31, 0, 59, 59), 3, 0);

    // Random words: mostly valid dates, some edge mixes, the rest raw bits.
    for (idx = 0; idx < RANDOM_WORDS; idx++) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        y  = $urandom_range(FIRST_YEAR, LAST_YEAR);
        mo = $urandom_range(1, 12);
        d  = $urandom_range(1, gregorian_month_days(y, mo));
        hr = $urandom_range(0, 23);
        mi = $urandom_range(0, 59);
        se = $urandom_range(0, 59);
      end else if (kind < 82) begin
        case ($urandom_range(0, 4))
          0:       y = FIRST_YEAR - 1;
          1:       y = FIRST_YEAR;
          2:       y = LAST_YEAR;
          3:       y = LAST_YEAR + 1;
          default: y = $urandom_range(FIRST_YEAR, LAST_YEAR);
        endcase
        mo  = $urandom_range(0, 13);
        len = gregorian_month_days(y, mo);
        case ($urandom_range(0, 4))
          0:       d = 0;
          1:       d = 1;
          2:       d = len;
          3:       d = len + 1;
          default: d = 31;
        endcase
        hr = ($urandom_range(0, 1) != 0) ? 23 + $urandom_range(0, 1) : $urandom_range(0, 23);
        mi = ($urandom_range(0, 1) != 0) ? 59 + $urandom_range(0, 1) : $urandom_range(0, 59);
        se = ($urandom_range(0, 1) != 0) ? 59 + $urandom_range(0, 1) : $urandom_range(0, 59);
      end else begin
        y  = $urandom_range(0, 4095);
        mo = $urandom_range(0, 15);
        d  = $urandom_range(0, 31);
        hr = $urandom_range(0, 31);
        mi = $urandom_range(0, 63);
        se = $urandom_range(0, 63);
      end
      // Alternate bursty and calm stretches; keep the tail back to back.
      bursty = ((idx / 100) % 3) != 2;
      gap = 0;
      if (bursty && idx < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 5);
      queue_date(make_date(y, mo, d, hr, mi, se), gap, (idx == 500) || (idx == 1100));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be taken and every result to come back.
    while (date_queue.size() != 0 || start) @(posedge clk);
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);

    if (mismatch_count == 0 && expected_epochs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
